// ===== rtl/mbe_pkg.sv =====
// ----------------------------------------------------------------------------
// mbe_pkg
// Shared constants, types and helpers for the escape-time pixel block.
// ----------------------------------------------------------------------------
`default_nettype none

package mbe_pkg;

    localparam int MAX_ITER   = 2000;
    localparam int PIXEL_BITS = 12;
    localparam int FRAC_BITS  = 28;

    localparam int Q_W      = 32;
    localparam int PIX_W    = 12;
    localparam int SIZE_W   = 13;
    localparam int COLOUR_W = 8;
    localparam int PROD_W   = PIXEL_BITS + Q_W;
    localparam int ITER_W   = $clog2(MAX_ITER + 1);
    localparam int DCNT_W   = $clog2(PROD_W + 1);
    localparam int ACC_W    = 40;

    localparam logic [COLOUR_W-1:0] COLOUR_FULL = '1;

    // register indexes
    localparam logic [2:0] REG_MIN_RE = 3'd0;
    localparam logic [2:0] REG_MAX_RE = 3'd1;
    localparam logic [2:0] REG_MIN_IM = 3'd2;
    localparam logic [2:0] REG_MAX_IM = 3'd3;
    localparam logic [2:0] REG_WIDTH  = 3'd4;
    localparam logic [2:0] REG_HEIGHT = 3'd5;

    localparam logic signed [Q_W-1:0] RST_MIN_RE = -32'sd671088640;
    localparam logic signed [Q_W-1:0] RST_MAX_RE = 32'sd402653184;
    localparam logic signed [Q_W-1:0] RST_MIN_IM = -32'sd335544320;
    localparam logic signed [Q_W-1:0] RST_MAX_IM = 32'sd335544320;
    localparam logic [SIZE_W-1:0]     RST_WIDTH  = 13'd1920;
    localparam logic [SIZE_W-1:0]     RST_HEIGHT = 13'd1200;

    // divider operand select
    localparam logic [1:0] DIV_SEL_RE  = 2'd0;
    localparam logic [1:0] DIV_SEL_IM  = 2'd1;
    localparam logic [1:0] DIV_SEL_COL = 2'd2;

    typedef struct packed {
        logic       load_px;
        logic       div_start;
        logic [1:0] div_sel;
        logic       c_re_load;
        logic       c_im_load;
        logic       z_clear;
        logic       mul_en;
        logic       step_en;
        logic       res_load;
    } mbe_cmd_t;

    typedef struct packed {
        logic div_done;
        logic in_radius;
        logic iter_max;
        logic iter_small;
    } mbe_sts_t;

    // lo + nonnegative offset, clipped at the top of the Q4.28 range
    function automatic logic signed [Q_W-1:0] sat_offset(
        input logic signed [Q_W-1:0] lo,
        input logic [PROD_W-1:0]     off
    );
        logic signed [PROD_W+1:0] sum;
        sum = $signed({{2{lo[Q_W-1]}}, {(PROD_W-Q_W){lo[Q_W-1]}}, lo})
            + $signed({2'b00, off});
        if (sum > $signed((PROD_W+2)'(64'sd2147483647))) begin
            return 32'sh7fff_ffff;
        end
        return sum[Q_W-1:0];
    endfunction

    function automatic logic signed [Q_W-1:0] sat_acc(input logic signed [ACC_W-1:0] v);
        if (v > 40'sd2147483647) begin
            return 32'sh7fff_ffff;
        end
        if (v < -40'sd2147483648) begin
            return 32'sh8000_0000;
        end
        return v[Q_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/mbe_div.sv =====
// ----------------------------------------------------------------------------
// mbe_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module mbe_div
    import mbe_pkg::*;
(
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 start,
    input  wire  [PROD_W-1:0]   dividend,
    input  wire  [SIZE_W-1:0]   divisor,
    output logic                done,
    output logic [PROD_W-1:0]   quotient
);

    logic [PROD_W-1:0] q_reg,    q_next;
    logic [SIZE_W-1:0] rem_reg,  rem_next;
    logic [SIZE_W-1:0] dsr_reg,  dsr_next;
    logic [DCNT_W-1:0] cnt_reg,  cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [SIZE_W:0]   trial;

    assign trial = {rem_reg, q_reg[PROD_W-1]};

    always_comb begin
        q_next    = q_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            q_next    = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
            cnt_next  = DCNT_W'(PROD_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, dsr_reg}) begin
                rem_next = SIZE_W'(trial - {1'b0, dsr_reg});
                q_next   = {q_reg[PROD_W-2:0], 1'b1};
            end else begin
                rem_next = trial[SIZE_W-1:0];
                q_next   = {q_reg[PROD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DCNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        q_reg   <= q_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

`default_nettype wire

// ===== rtl/mbe_datapath.sv =====
// ----------------------------------------------------------------------------
// mbe_datapath
// Window registers, coordinate mapping, z*z + c iteration and colour result.
// ----------------------------------------------------------------------------
`default_nettype none

module mbe_datapath
    import mbe_pkg::*;
(
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  cfg_wr_en,
    input  wire  [2:0]           cfg_index,
    input  wire  [Q_W-1:0]       cfg_wdata,
    input  wire  [PIX_W-1:0]     pixel_x,
    input  wire  [PIX_W-1:0]     pixel_y,
    input  wire  mbe_cmd_t       cmd,
    output mbe_sts_t             sts,
    output logic [3*COLOUR_W-1:0] rgb,
    output logic                 in_set
);

    logic signed [Q_W-1:0]   min_re_reg, max_re_reg, min_im_reg, max_im_reg;
    logic [SIZE_W-1:0]       width_reg, height_reg;
    logic [PIXEL_BITS-1:0]   px_reg, py_reg;
    logic signed [Q_W-1:0]   c_re_reg, c_im_reg;
    logic signed [Q_W-1:0]   x_reg, y_reg;
    logic signed [2*Q_W-1:0] xx_reg, yy_reg, xy_reg;
    logic [ITER_W-1:0]       iter_reg;
    logic [3*COLOUR_W-1:0]   rgb_reg;
    logic                    in_set_reg;

    // divider operands
    logic signed [Q_W-1:0]   lo_sel, hi_sel;
    logic [SIZE_W-1:0]       size_sel;
    logic [PIXEL_BITS-1:0]   pix_sel;
    logic signed [Q_W:0]     diff;
    logic [Q_W-1:0]          span;
    logic [PROD_W-1:0]       dvd;
    logic [SIZE_W-1:0]       dsr;
    logic                    div_done;
    logic [PROD_W-1:0]       quot;

    always_comb begin
        lo_sel   = min_re_reg;
        hi_sel   = max_re_reg;
        size_sel = width_reg;
        pix_sel  = px_reg;
        if (cmd.div_sel == DIV_SEL_IM) begin
            lo_sel   = min_im_reg;
            hi_sel   = max_im_reg;
            size_sel = height_reg;
            pix_sel  = py_reg;
        end
        diff = $signed({hi_sel[Q_W-1], hi_sel}) - $signed({lo_sel[Q_W-1], lo_sel});
        span = diff[Q_W] ? Q_W'(-diff) : diff[Q_W-1:0];
        unique case (cmd.div_sel) inside
            DIV_SEL_RE, DIV_SEL_IM: begin
                dvd = PROD_W'(pix_sel) * PROD_W'(span);
                dsr = (size_sel == '0) ? SIZE_W'(1) : size_sel;
            end
            DIV_SEL_COL: begin
                dvd = PROD_W'(COLOUR_FULL);
                dsr = SIZE_W'(iter_reg);
            end
            default: begin
                dvd = '0;
                dsr = SIZE_W'(1);
            end
        endcase
    end

    mbe_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (dvd),
        .divisor  (dsr),
        .done     (div_done),
        .quotient (quot)
    );

    // iteration arithmetic
    logic [2*Q_W-1:0]        mag_sum;
    logic signed [2*Q_W-1:0] re_diff;
    logic signed [ACC_W-1:0] nx_acc, ny_acc;

    assign mag_sum = xx_reg + yy_reg;
    assign re_diff = xx_reg - yy_reg;
    assign nx_acc  = ACC_W'($signed(re_diff[2*Q_W-1:FRAC_BITS])) + ACC_W'(c_re_reg);
    assign ny_acc  = ACC_W'($signed(xy_reg[2*Q_W-1:FRAC_BITS-1])) + ACC_W'(c_im_reg);

    assign sts.div_done   = div_done;
    assign sts.in_radius  = (mag_sum[2*Q_W-1:2*FRAC_BITS+2] == '0);
    assign sts.iter_max   = (iter_reg == ITER_W'(MAX_ITER));
    assign sts.iter_small = (32'(iter_reg) <= 32'(COLOUR_FULL));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_re_reg <= RST_MIN_RE;
            max_re_reg <= RST_MAX_RE;
            min_im_reg <= RST_MIN_IM;
            max_im_reg <= RST_MAX_IM;
            width_reg  <= RST_WIDTH;
            height_reg <= RST_HEIGHT;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_MIN_RE: min_re_reg <= cfg_wdata;
                REG_MAX_RE: max_re_reg <= cfg_wdata;
                REG_MIN_IM: min_im_reg <= cfg_wdata;
                REG_MAX_IM: max_im_reg <= cfg_wdata;
                REG_WIDTH:  width_reg  <= cfg_wdata[SIZE_W-1:0];
                REG_HEIGHT: height_reg <= cfg_wdata[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_px) begin
            px_reg <= pixel_x[PIXEL_BITS-1:0];
            py_reg <= pixel_y[PIXEL_BITS-1:0];
        end
        if (cmd.c_re_load) begin
            c_re_reg <= sat_offset(min_re_reg, quot);
        end
        if (cmd.c_im_load) begin
            c_im_reg <= sat_offset(min_im_reg, quot);
        end
        if (cmd.z_clear) begin
            x_reg    <= '0;
            y_reg    <= '0;
            iter_reg <= '0;
        end else if (cmd.step_en) begin
            x_reg    <= sat_acc(nx_acc);
            y_reg    <= sat_acc(ny_acc);
            iter_reg <= iter_reg + 1'b1;
        end
        if (cmd.mul_en) begin
            xx_reg <= x_reg * x_reg;
            yy_reg <= y_reg * y_reg;
            xy_reg <= x_reg * y_reg;
        end
        if (cmd.res_load) begin
            if (sts.in_radius) begin
                rgb_reg    <= '1;
                in_set_reg <= 1'b1;
            end else begin
                rgb_reg[COLOUR_W-1:0]          <= sts.iter_small
                                                  ? COLOUR_FULL - quot[COLOUR_W-1:0]
                                                  : COLOUR_FULL;
                rgb_reg[3*COLOUR_W-1:COLOUR_W] <= '0;
                in_set_reg                     <= 1'b0;
            end
        end
    end

    assign rgb    = rgb_reg;
    assign in_set = in_set_reg;

endmodule

`default_nettype wire

// ===== rtl/mbe_ctrl.sv =====
// ----------------------------------------------------------------------------
// mbe_ctrl
// Sequencer: mapping divides, iteration loop, colour divide, result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module mbe_ctrl
    import mbe_pkg::*;
(
    input  wire       aclk,
    input  wire       aresetn,
    input  wire       s_tvalid,
    output logic      s_tready,
    output logic      m_tvalid,
    input  wire       m_tready,
    input  wire mbe_sts_t sts,
    output mbe_cmd_t  cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_DIV_RE = 3'd1;
    localparam logic [2:0] ST_DIV_IM = 3'd2;
    localparam logic [2:0] ST_MUL    = 3'd3;
    localparam logic [2:0] ST_STEP   = 3'd4;
    localparam logic [2:0] ST_COLOUR = 3'd5;
    localparam logic [2:0] ST_WRITE  = 3'd6;

    logic [2:0] state_reg, state_next;
    logic       mvalid_reg, mvalid_next;
    // first divide is launched the cycle after the pixel is latched
    logic       start_re_reg;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.div_sel = DIV_SEL_RE;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_px = 1'b1;
                    state_next  = ST_DIV_RE;
                end
            end
            ST_DIV_RE: begin
                // start on entry, wait for done
                cmd.div_sel   = DIV_SEL_RE;
                cmd.div_start = start_re_reg;
                if (sts.div_done) begin
                    cmd.c_re_load = 1'b1;
                    cmd.div_sel   = DIV_SEL_IM;
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV_IM;
                end
            end
            ST_DIV_IM: begin
                cmd.div_sel = DIV_SEL_IM;
                if (sts.div_done) begin
                    cmd.c_im_load = 1'b1;
                    cmd.z_clear   = 1'b1;
                    state_next    = ST_MUL;
                end
            end
            ST_MUL: begin
                cmd.mul_en = 1'b1;
                state_next = ST_STEP;
            end
            ST_STEP: begin
                if (!sts.in_radius) begin
                    if (sts.iter_small) begin
                        cmd.div_sel   = DIV_SEL_COL;
                        cmd.div_start = 1'b1;
                        state_next    = ST_COLOUR;
                    end else begin
                        state_next = ST_WRITE;
                    end
                end else if (sts.iter_max) begin
                    state_next = ST_WRITE;
                end else begin
                    cmd.step_en = 1'b1;
                    state_next  = ST_MUL;
                end
            end
            ST_COLOUR: begin
                cmd.div_sel = DIV_SEL_COL;
                if (sts.div_done) begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE: begin
                if (!mvalid_reg || m_tready) begin
                    cmd.res_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        mvalid_next = mvalid_reg;
        if (cmd.res_load) begin
            mvalid_next = 1'b1;
        end else if (m_tready) begin
            mvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            mvalid_reg   <= 1'b0;
            start_re_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            mvalid_reg   <= mvalid_next;
            start_re_reg <= cmd.load_px;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = mvalid_reg;

endmodule

`default_nettype wire

// ===== rtl/mandelbrot_escape_time_pixel.sv =====
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_pixel
// Escape-time colouring of one pixel of a Mandelbrot window.
// ----------------------------------------------------------------------------
//  channel   | direction | tdata                          | tuser
//  s_        | in        | pixel_x[11:0], pixel_y[23:12]  | -
//  m_        | out       | red[7:0], green[15:8],         | in_set[0]
//            |           | blue[23:16]                    |
//  cfg_      | in        | write only, index 0..5         | -
//
//  Per pixel: two mapping divides, then the ST_MUL/ST_STEP loop for each
//  iteration run (up to 2000), plus a colour divide when the point escapes
//  within 255 iterations; all divides use the shared 44-step restoring
//  divider. A new request is taken while the last result waits on m_tready.
//  Reset is synchronous, window at default values.
// ----------------------------------------------------------------------------
`default_nettype none

module mandelbrot_escape_time_pixel
    import mbe_pkg::*;
(
    input  wire                     aclk,
    input  wire                     aresetn,
    input  wire                     cfg_wr_en,
    input  wire  [2:0]              cfg_index,
    input  wire  [Q_W-1:0]          cfg_wdata,
    input  wire                     s_tvalid,
    output logic                    s_tready,
    input  wire  [2*PIX_W-1:0]      s_tdata,   // pixel_x, pixel_y
    output logic                    m_tvalid,
    input  wire                     m_tready,
    output logic [3*COLOUR_W-1:0]   m_tdata,   // red, green, blue
    output logic                    m_tuser    // in_set
);

    mbe_cmd_t cmd;
    mbe_sts_t sts;

    mbe_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    mbe_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .pixel_x   (s_tdata[PIX_W-1:0]),
        .pixel_y   (s_tdata[2*PIX_W-1:PIX_W]),
        .cmd       (cmd),
        .sts       (sts),
        .rgb       (m_tdata),
        .in_set    (m_tuser)
    );

endmodule

`default_nettype wire

// ===== rtl/mbe_chk.sv =====
// ----------------------------------------------------------------------------
// mbe_chk
// Port-level checks for the escape-time pixel block.
// ----------------------------------------------------------------------------
`default_nettype none

module mbe_chk
    import mbe_pkg::*;
(
    input wire                   aclk,
    input wire                   aresetn,
    input wire                   s_tvalid,
    input wire                   s_tready,
    input wire                   m_tvalid,
    input wire                   m_tready,
    input wire [3*COLOUR_W-1:0]  m_tdata,
    input wire                   m_tuser
);

    a_valid_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second request taken while busy");

    a_white_in_set: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == '1)
        else $error("bounded point not white");

    a_escaped_red: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata[3*COLOUR_W-1:COLOUR_W] == '0)
        else $error("escaped point has green or blue");

    a_reset_idle: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind mandelbrot_escape_time_pixel mbe_chk u_chk (.*);

`default_nettype wire

// ===== tb/mandelbrot_escape_time_pixel_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_pixel_checker
// Watches the register port and both streams of the escape-time block. It
// keeps its own copy of the window registers and, for every accepted pixel
// request, works out the colour in Q4.28 fixed point. Each returned colour is
// compared field by field with the oldest outstanding prediction.
// ----------------------------------------------------------------------------

module mandelbrot_escape_time_pixel_checker
    import mbe_pkg::*;
(
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   cfg_wr_en,
    input  wire  [2:0]            cfg_index,
    input  wire  [Q_W-1:0]        cfg_wdata,
    input  wire                   s_tvalid,
    input  wire                   s_tready,
    input  wire  [2*PIX_W-1:0]    s_tdata,   // pixel_x, pixel_y
    input  wire                   m_tvalid,
    input  wire                   m_tready,
    input  wire  [3*COLOUR_W-1:0] m_tdata,   // red, green, blue
    input  wire                   m_tuser,   // in_set
    output int                    fail_count,
    output int                    pending_count
);

    typedef struct packed {
        logic [COLOUR_W-1:0] red;
        logic [COLOUR_W-1:0] green;
        logic [COLOUR_W-1:0] blue;
        logic                in_set;
    } pixel_colour_t;

    logic signed [Q_W-1:0] min_re;
    logic signed [Q_W-1:0] max_re;
    logic signed [Q_W-1:0] min_im;
    logic signed [Q_W-1:0] max_im;
    logic [SIZE_W-1:0]     width_px;
    logic [SIZE_W-1:0]     height_px;

    pixel_colour_t colour_q[$];
    pixel_colour_t want;

    function automatic logic signed [Q_W-1:0] clamp_q(input longint v);
        if (v > 64'sd2147483647) begin
            return 32'sh7fff_ffff;
        end
        if (v < -64'sd2147483648) begin
            return 32'sh8000_0000;
        end
        return v[Q_W-1:0];
    endfunction

    // lo + floor(pix * |hi - lo| / size), size 0 divides as 1
    function automatic logic signed [Q_W-1:0] plane_coord(
        input logic [PIX_W-1:0]      pix,
        input logic signed [Q_W-1:0] lo,
        input logic signed [Q_W-1:0] hi,
        input logic [SIZE_W-1:0]     size
    );
        longint          d;
        longint unsigned span;
        longint unsigned dv;
        longint unsigned off;
        d    = longint'(hi) - longint'(lo);
        span = (d < 0) ? -d : d;
        dv   = (size == 0) ? 64'd1 : 64'(size);
        off  = (64'(pix) * span) / dv;
        return clamp_q(longint'(lo) + longint'(off));
    endfunction

    function automatic bit within_radius(
        input logic signed [Q_W-1:0] re,
        input logic signed [Q_W-1:0] im
    );
        longint unsigned ar;
        longint unsigned ai;
        ar = (re < 0) ? -longint'(re) : longint'(re);
        ai = (im < 0) ? -longint'(im) : longint'(im);
        return (ar * ar + ai * ai) < (64'd4 << (2 * FRAC_BITS));
    endfunction

    function automatic pixel_colour_t escape_colour(
        input logic [PIX_W-1:0] px,
        input logic [PIX_W-1:0] py
    );
        logic signed [Q_W-1:0] c_re;
        logic signed [Q_W-1:0] c_im;
        logic signed [Q_W-1:0] z_re;
        logic signed [Q_W-1:0] z_im;
        logic signed [Q_W-1:0] n_re;
        longint                sq_re;
        longint                sq_im;
        longint                prod_xy;
        int unsigned           iter;
        pixel_colour_t         res;
        c_re = plane_coord(px, min_re, max_re, width_px);
        c_im = plane_coord(py, min_im, max_im, height_px);
        z_re = '0;
        z_im = '0;
        iter = 0;
        while (iter < MAX_ITER && within_radius(z_re, z_im)) begin
            sq_re   = longint'(z_re) * longint'(z_re);
            sq_im   = longint'(z_im) * longint'(z_im);
            prod_xy = 2 * (longint'(z_re) * longint'(z_im));
            // arithmetic shift gives floor on the products
            n_re  = clamp_q(((sq_re - sq_im) >>> FRAC_BITS) + longint'(c_re));
            z_im  = clamp_q((prod_xy >>> FRAC_BITS) + longint'(c_im));
            z_re  = n_re;
            iter++;
        end
        if (!within_radius(z_re, z_im)) begin
            res.red    = COLOUR_W'(255 - 255 / ((iter == 0) ? 1 : iter));
            res.green  = '0;
            res.blue   = '0;
            res.in_set = 1'b0;
        end else begin
            res.red    = COLOUR_FULL;
            res.green  = COLOUR_FULL;
            res.blue   = COLOUR_FULL;
            res.in_set = 1'b1;
        end
        return res;
    endfunction

    task automatic check_field(
        input string               name,
        input logic [COLOUR_W-1:0] exp_v,
        input logic [COLOUR_W-1:0] act_v
    );
        if (act_v !== exp_v) begin
            $display("%0t ns: %s expected %0d actual %0d", $time, name, exp_v, act_v);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            min_re    = RST_MIN_RE;
            max_re    = RST_MAX_RE;
            min_im    = RST_MIN_IM;
            max_im    = RST_MAX_IM;
            width_px  = RST_WIDTH;
            height_px = RST_HEIGHT;
            colour_q.delete();
            pending_count = 0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_MIN_RE: min_re    = cfg_wdata;
                    REG_MAX_RE: max_re    = cfg_wdata;
                    REG_MIN_IM: min_im    = cfg_wdata;
                    REG_MAX_IM: max_im    = cfg_wdata;
                    REG_WIDTH:  width_px  = cfg_wdata[SIZE_W-1:0];
                    REG_HEIGHT: height_px = cfg_wdata[SIZE_W-1:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                if (colour_q.size() == 0) begin
                    $display("%0t ns: colour expected none actual %h in_set %b",
                             $time, m_tdata, m_tuser);
                    fail_count++;
                end else begin
                    want = colour_q.pop_front();
                    check_field("red", want.red, m_tdata[COLOUR_W-1:0]);
                    check_field("green", want.green, m_tdata[2*COLOUR_W-1:COLOUR_W]);
                    check_field("blue", want.blue, m_tdata[3*COLOUR_W-1:2*COLOUR_W]);
                    check_field("in_set", COLOUR_W'(want.in_set), COLOUR_W'(m_tuser));
                end
            end
            if (s_tvalid && s_tready) begin
                colour_q.push_back(escape_colour(s_tdata[PIX_W-1:0],
                                                 s_tdata[2*PIX_W-1:PIX_W]));
            end
            pending_count = colour_q.size();
        end
    end

endmodule

// ===== tb/mandelbrot_escape_time_pixel_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_pixel_test
// Stimulus for the escape-time pixel block. Directed pixels cover the image
// corners, saturating and zero-size windows and points near the cusp of the
// set that need close to the full iteration count; random phases follow with
// varied windows and sizes. Both streams idle at random, the result side
// holds off once for a long stretch. Checking is done by the checker module.
// ----------------------------------------------------------------------------

module mandelbrot_escape_time_pixel_test;
    import mbe_pkg::*;

    localparam logic [2:0]            REG_NONE  = 3'd7;
    localparam int                    LONG_HOLD = 20000;
    localparam int                    END_WAIT  = 5000;
    localparam logic signed [Q_W-1:0] Q_TOP     = 32'sh7fff_ffff;
    localparam logic signed [Q_W-1:0] Q_BOTTOM  = 32'sh8000_0000;
    localparam logic signed [Q_W-1:0] QUARTER   = 32'sd67108864;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [2:0]             cfg_index = '0;
    logic [Q_W-1:0]         cfg_wdata = '0;
    logic                   s_tvalid  = 1'b0;
    logic [2*PIX_W-1:0]     s_tdata   = '0;
    logic                   m_tready  = 1'b0;
    logic                   s_tready;
    logic                   m_tvalid;
    logic [3*COLOUR_W-1:0]  m_tdata;
    logic                   m_tuser;

    int fail_count;
    int pending_count;
    int sent;
    int got;
    bit tx_idle_en;
    bit rx_idle_en;
    bit long_hold;

    mandelbrot_escape_time_pixel DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    mandelbrot_escape_time_pixel_checker colour_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    initial begin
        #30_000_000;
        $display("mandelbrot_escape_time_pixel test failed");
        $finish;
    end

    // result side: random gaps per colour, one long hold-off on request
    initial begin : colour_sink
        int gap;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            gap = rx_idle_en ? $urandom_range(0, 8) : 0;
            if (long_hold) begin
                gap       = LONG_HOLD;
                long_hold = 1'b0;
            end
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!(m_tvalid && m_tready)) @(posedge aclk);
            got++;
        end
    end

    task automatic send_pixel(input logic [PIX_W-1:0] px, input logic [PIX_W-1:0] py);
        int gap;
        gap = tx_idle_en ? $urandom_range(0, 8) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {py, px};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sent++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (got != sent) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [Q_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
    endtask

    task automatic load_window(
        input logic signed [Q_W-1:0] lo_re,
        input logic signed [Q_W-1:0] hi_re,
        input logic signed [Q_W-1:0] lo_im,
        input logic signed [Q_W-1:0] hi_im,
        input logic [SIZE_W-1:0]     w,
        input logic [SIZE_W-1:0]     h
    );
        drain();
        write_reg(REG_MIN_RE, lo_re);
        write_reg(REG_MAX_RE, hi_re);
        write_reg(REG_MIN_IM, lo_im);
        write_reg(REG_MAX_IM, hi_im);
        write_reg(REG_WIDTH, Q_W'(w));
        write_reg(REG_HEIGHT, Q_W'(h));
        cfg_wr_en <= 1'b0;
    endtask

    initial begin : pixel_source
        int p;
        int k;
        int lo_re;
        int lo_im;
        int span_re;
        int span_im;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset window, no idling
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd4095);
        send_pixel(12'd0, 12'd4095);
        send_pixel(12'd4095, 12'd0);
        send_pixel(12'd1280, 12'd600);
        send_pixel(12'd2730, 12'd1365);

        // full-range window, zero width: c saturates
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        drain();
        write_reg(REG_NONE, $urandom);
        load_window(Q_BOTTOM, Q_TOP, Q_TOP, Q_BOTTOM, 13'd0, 13'd1);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd4095);
        send_pixel(12'd1, 12'd0);

        // left edge near the top, offset runs past the range
        load_window(32'sh7fff_f000, 32'sh0, Q_BOTTOM, Q_BOTTOM, 13'd8191, 13'd4096);
        send_pixel(12'd4095, 12'd0);
        send_pixel(12'd0, 12'd4095);
        send_pixel(12'd1, 12'd1);

        // one LSB per pixel just right of the cusp: escape near the limit
        tx_idle_en = 1'b0;
        load_window(QUARTER + 640, QUARTER + 640 + 4096, 32'sh0, 32'sh0, 13'd4096, 13'd1);
        for (k = 0; k < 12; k++) begin
            send_pixel(PIX_W'(3 * k), PIX_W'($urandom_range(0, 4095)));
        end

        for (p = 0; p < 6; p++) begin
            tx_idle_en = (p % 3) != 2;
            rx_idle_en = (p % 3) != 1;
            case (p % 3)
                0: begin
                    load_window($urandom, $urandom, $urandom, $urandom,
                                SIZE_W'($urandom_range(0, 8191)),
                                SIZE_W'($urandom_range(0, 8191)));
                end
                1: begin
                    lo_re   = $urandom_range(0, 536870912) - 805306368;
                    span_re = $urandom_range(805306368, 1073741824);
                    lo_im   = $urandom_range(0, 268435456) - 469762048;
                    span_im = $urandom_range(536870912, 805306368);
                    if ($urandom_range(0, 1)) begin
                        load_window(lo_re, lo_re + span_re, lo_im + span_im, lo_im,
                                    SIZE_W'($urandom_range(1, 4096)),
                                    SIZE_W'($urandom_range(1, 4096)));
                    end else begin
                        load_window(lo_re, lo_re + span_re, lo_im, lo_im + span_im,
                                    SIZE_W'($urandom_range(1, 4096)),
                                    SIZE_W'($urandom_range(1, 4096)));
                    end
                end
                default: begin
                    lo_re   = $urandom_range(0, 671088640) - 536870912;
                    lo_im   = $urandom_range(0, 671088640) - 335544320;
                    span_re = 1 << $urandom_range(18, 28);
                    load_window(lo_re, lo_re + span_re, lo_im, lo_im + span_re,
                                SIZE_W'($urandom_range(1, 4096)),
                                SIZE_W'($urandom_range(1, 4096)));
                end
            endcase
            for (k = 0; k < 50; k++) begin
                // fast window: block fills while the result side holds off
                if (p == 0 && k == 10) begin
                    long_hold = 1'b1;
                end
                send_pixel(PIX_W'($urandom_range(0, 4095)), PIX_W'($urandom_range(0, 4095)));
            end
        end

        drain();
        repeat (END_WAIT) @(posedge aclk);
        if (fail_count == 0 && pending_count == 0) begin
            $display("mandelbrot_escape_time_pixel test passed");
        end else begin
            $display("mandelbrot_escape_time_pixel test failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/mbe_pkg.sv
rtl/mbe_div.sv
rtl/mbe_datapath.sv
rtl/mbe_ctrl.sv
rtl/mandelbrot_escape_time_pixel.sv
rtl/mbe_chk.sv
tb/mandelbrot_escape_time_pixel_checker.sv
tb/mandelbrot_escape_time_pixel_test.sv
